// File: hdl/sse_pkg.sv
// ---------------------------------------------------------------------------
// sse_pkg
// Shared types, constants and helper functions of the subset sum enumerator.
// ---------------------------------------------------------------------------
package sse_pkg;

  // largest element the search handles
  localparam int unsigned MAX_ELEMENTS = 32;

  // field and state widths
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // register index codes (taken from paddr[2])
  localparam logic REG_SET_SIZE   = 1'b0;
  localparam logic REG_TARGET_SUM = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESCEND,
    ST_BACKUP,
    ST_DONE
  } sse_state_t;

  // evaluation of one search step, step unit to sequencer
  typedef struct packed {
    logic              hit;       // running sum equals target
    logic              dead;      // current branch cannot reach target
    logic              j_zero;    // backtrack scan ran off the bottom
    logic              j_bit;     // scanned element is in the subset
    logic [MASK_W-1:0] inc_mask;  // state after including the next element
    logic [SUM_W-1:0]  inc_sum;
    logic [IDX_W-1:0]  inc_idx;
    logic [MASK_W-1:0] bk_mask;   // state after dropping the scanned element
    logic [SUM_W-1:0]  bk_sum;
    logic [IDX_W-1:0]  bk_idx;
  } sse_step_t;

  // triangular number k*(k+1)/2 for k up to MAX_ELEMENTS
  function automatic logic [SUM_W-1:0] tri_num(input logic [IDX_W-1:0] k);
    logic [2*IDX_W-1:0] p;
    p = (2*IDX_W)'(k) * ((2*IDX_W)'(k) + (2*IDX_W)'(1));
    return p[SUM_W:1];
  endfunction

  // set size capped at MAX_ELEMENTS
  function automatic logic [IDX_W-1:0] eff_size(input logic [IDX_W-1:0] n);
    return (n > IDX_W'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS) : n;
  endfunction

endpackage

// File: hdl/sse_step_unit.sv
// ---------------------------------------------------------------------------
// sse_step_unit
// Shared step evaluator: judges the current search node for a descent step
// and tests one element for a backtracking step.
// ---------------------------------------------------------------------------
module sse_step_unit (
  input  logic [sse_pkg::IDX_W-1:0]  set_size,
  input  logic [sse_pkg::SUM_W-1:0]  target_sum,
  input  logic [sse_pkg::MASK_W-1:0] mask,
  input  logic [sse_pkg::IDX_W-1:0]  idx,
  input  logic [sse_pkg::SUM_W-1:0]  sum,
  input  logic [sse_pkg::IDX_W-1:0]  scan_j,
  output sse_pkg::sse_step_t         step
);

  logic [sse_pkg::IDX_W-1:0]  n_eff;
  logic [sse_pkg::SUM_W:0]    sum_plus_i;
  logic [sse_pkg::SUM_W-1:0]  rem;
  logic [sse_pkg::SUM_W:0]    sum_plus_rem;
  logic [sse_pkg::IDX_W-1:0]  i_m1;
  logic [sse_pkg::IDX_W-1:0]  j_m1;
  logic                       over_n;

  assign n_eff  = sse_pkg::eff_size(set_size);
  assign i_m1   = idx - sse_pkg::IDX_W'(1);
  assign j_m1   = scan_j - sse_pkg::IDX_W'(1);
  assign over_n = idx > n_eff;

  // pruning bounds: overshoot and what is left to add
  assign sum_plus_i   = (sse_pkg::SUM_W+1)'(sum) + (sse_pkg::SUM_W+1)'(idx);
  assign rem          = sse_pkg::tri_num(n_eff) - sse_pkg::tri_num(i_m1);
  assign sum_plus_rem = (sse_pkg::SUM_W+1)'(sum) + (sse_pkg::SUM_W+1)'(rem);

  always_comb begin
    step.hit  = sum == target_sum;
    step.dead = over_n
             || (sum_plus_i > (sse_pkg::SUM_W+1)'(target_sum))
             || (sum_plus_rem < (sse_pkg::SUM_W+1)'(target_sum));

    // include the next element
    step.inc_mask = mask;
    step.inc_mask[i_m1[sse_pkg::BIT_W-1:0]] = 1'b1;
    step.inc_sum  = sum + sse_pkg::SUM_W'(idx);
    step.inc_idx  = idx + sse_pkg::IDX_W'(1);

    // backtrack scan: test one element, drop it if it was chosen
    step.j_zero  = scan_j == '0;
    step.j_bit   = mask[j_m1[sse_pkg::BIT_W-1:0]];
    step.bk_mask = mask;
    step.bk_mask[j_m1[sse_pkg::BIT_W-1:0]] = 1'b0;
    step.bk_sum  = sum - sse_pkg::SUM_W'(scan_j);
    step.bk_idx  = scan_j + sse_pkg::IDX_W'(1);
  end

endmodule

// File: hdl/sse_ctrl.sv
// ---------------------------------------------------------------------------
// sse_ctrl
// Search sequencer: holds the search state, steps it through the shared
// step unit and loads the result word into the output register.
// ---------------------------------------------------------------------------
module sse_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sse_pkg::IDX_W-1:0]  set_size,
  input  logic [sse_pkg::SUM_W-1:0]  target_sum,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sse_pkg::MASK_W-1:0] out_subset_mask,
  output logic                       out_found,
  output logic [sse_pkg::CNT_W-1:0]  out_solution_count,
  input  sse_pkg::sse_step_t         step,
  output logic [sse_pkg::MASK_W-1:0] mask,
  output logic [sse_pkg::IDX_W-1:0]  idx,
  output logic [sse_pkg::SUM_W-1:0]  sum,
  output logic [sse_pkg::IDX_W-1:0]  scan_j
);

  sse_pkg::sse_state_t        state_r, state_nxt;
  logic [sse_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic [sse_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [sse_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [sse_pkg::IDX_W-1:0]  j_r, j_nxt;
  logic [sse_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic                       over_r, over_nxt;
  logic                       got_r, got_nxt;
  logic                       oval_r, oval_nxt;
  logic [sse_pkg::MASK_W-1:0] omask_r, omask_nxt;
  logic                       ofound_r, ofound_nxt;
  logic [sse_pkg::CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic                       accept;
  logic                       out_free;

  assign accept   = in_valid && (state_r == sse_pkg::ST_IDLE);
  assign out_free = !oval_r || !out_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sse_pkg::ST_IDLE;
      mask_r  <= '0;
      idx_r   <= sse_pkg::IDX_W'(1);
      sum_r   <= '0;
      total_r <= '0;
      over_r  <= 1'b1;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      total_r <= total_nxt;
      over_r  <= over_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    got_r    <= got_nxt;
    omask_r  <= omask_nxt;
    ofound_r <= ofound_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    mask_nxt   = mask_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    j_nxt      = j_r;
    total_nxt  = total_r;
    over_nxt   = over_r;
    got_nxt    = got_r;
    omask_nxt  = omask_r;
    ofound_nxt = ofound_r;
    ocnt_nxt   = ocnt_r;
    oval_nxt   = oval_r && out_stall;

    case (state_r)
      sse_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            mask_nxt  = '0;
            idx_nxt   = sse_pkg::IDX_W'(1);
            sum_nxt   = '0;
            total_nxt = '0;
            over_nxt  = (set_size == '0) || (target_sum == '0);
            got_nxt   = 1'b0;
            state_nxt = over_nxt ? sse_pkg::ST_DONE : sse_pkg::ST_DESCEND;
          end else if (over_r) begin
            got_nxt   = 1'b0;
            state_nxt = sse_pkg::ST_DONE;
          end else begin
            // leave the last solution through its latest inclusion
            j_nxt     = idx_r - sse_pkg::IDX_W'(1);
            state_nxt = sse_pkg::ST_BACKUP;
          end
        end
      end

      sse_pkg::ST_DESCEND: begin
        if (step.hit) begin
          got_nxt   = 1'b1;
          state_nxt = sse_pkg::ST_DONE;
        end else if (!step.dead) begin
          mask_nxt = step.inc_mask;
          sum_nxt  = step.inc_sum;
          idx_nxt  = step.inc_idx;
        end else begin
          j_nxt     = idx_r - sse_pkg::IDX_W'(1);
          state_nxt = sse_pkg::ST_BACKUP;
        end
      end

      sse_pkg::ST_BACKUP: begin
        if (step.j_zero) begin
          got_nxt   = 1'b0;
          state_nxt = sse_pkg::ST_DONE;
        end else if (step.j_bit) begin
          mask_nxt  = step.bk_mask;
          sum_nxt   = step.bk_sum;
          idx_nxt   = step.bk_idx;
          state_nxt = sse_pkg::ST_DESCEND;
        end else begin
          j_nxt = j_r - sse_pkg::IDX_W'(1);
        end
      end

      sse_pkg::ST_DONE: begin
        // hand the result word over once the output register is free
        if (out_free) begin
          if (got_r) begin
            if (total_r != '1) begin
              total_nxt = total_r + sse_pkg::CNT_W'(1);
            end
          end else begin
            over_nxt = 1'b1;
          end
          omask_nxt  = got_r ? mask_r : '0;
          ofound_nxt = got_r;
          ocnt_nxt   = total_nxt;
          oval_nxt   = 1'b1;
          state_nxt  = sse_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sse_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall           = state_r != sse_pkg::ST_IDLE;
  assign out_valid          = oval_r;
  assign out_subset_mask    = omask_r;
  assign out_found          = ofound_r;
  assign out_solution_count = ocnt_r;
  assign mask               = mask_r;
  assign idx                = idx_r;
  assign sum                = sum_r;
  assign scan_j             = j_r;

endmodule

// File: hdl/subset_sum_enumerator_top.sv
// ---------------------------------------------------------------------------
// subset_sum_enumerator_top
// Enumerates, one word per request, the subsets of 1..n that sum to a target.
// ---------------------------------------------------------------------------
// Each request word (restart=1 starts over, restart=0 asks for the next
// subset) returns one result word: the subset as a bit mask, a found flag
// and the saturating count of subsets since the last restart; found=0 with
// a zero mask means the search is exhausted. The search is a depth-first
// backtracking walk driven by one shared step unit: each step of the walk
// either judges and extends the current branch or tests one element while
// backtracking, and the result word is then loaded into the output register;
// how long a request takes is data dependent. in_stall stays high while a
// request is being worked on. set_size sits at byte address 0 and target_sum
// at 4 on the configuration port; both must be written only while the block
// is idle, and the block itself does not enforce this.
// ---------------------------------------------------------------------------
module subset_sum_enumerator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sse_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [sse_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [sse_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sse_pkg::MASK_W-1:0]  out_subset_mask,
  output logic                        out_found,
  output logic [sse_pkg::CNT_W-1:0]   out_solution_count
);

  logic [sse_pkg::IDX_W-1:0]  set_size_r;
  logic [sse_pkg::SUM_W-1:0]  target_sum_r;
  logic                       cfg_wr;
  logic                       reg_sel;
  sse_pkg::sse_step_t         step;
  logic [sse_pkg::MASK_W-1:0] mask;
  logic [sse_pkg::IDX_W-1:0]  idx;
  logic [sse_pkg::SUM_W-1:0]  sum;
  logic [sse_pkg::IDX_W-1:0]  scan_j;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r   <= sse_pkg::IDX_W'(1);
      target_sum_r <= sse_pkg::SUM_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        sse_pkg::REG_SET_SIZE:   set_size_r   <= cfg_pwdata[sse_pkg::IDX_W-1:0];
        sse_pkg::REG_TARGET_SUM: target_sum_r <= cfg_pwdata[sse_pkg::SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      sse_pkg::REG_SET_SIZE:   cfg_prdata = sse_pkg::APB_DW'(set_size_r);
      sse_pkg::REG_TARGET_SUM: cfg_prdata = sse_pkg::APB_DW'(target_sum_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  sse_step_unit u_step (
    .set_size   (set_size_r),
    .target_sum (target_sum_r),
    .mask       (mask),
    .idx        (idx),
    .sum        (sum),
    .scan_j     (scan_j),
    .step       (step)
  );

  sse_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .set_size           (set_size_r),
    .target_sum         (target_sum_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_subset_mask    (out_subset_mask),
    .out_found          (out_found),
    .out_solution_count (out_solution_count),
    .step               (step),
    .mask               (mask),
    .idx                (idx),
    .sum                (sum),
    .scan_j             (scan_j)
  );

`ifndef ASSERT_OFF
  // a taken request makes the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block not busy");

  // an exhausted search reports an empty mask
  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_subset_mask == '0))
    else $error("mask not empty on exhausted search");

  // a found subset is always counted
  a_count_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_solution_count != '0))
    else $error("found subset with zero count");
`endif

endmodule
